>>> rtl/core/text_cache_lru_lookup_core_defines.svh
// ----------------------------------------------------------------------------
// Text cache LRU lookup core: assertion macros
// Shared property forms for the checker of the lookup core.
// ----------------------------------------------------------------------------
`ifndef TEXT_CACHE_LRU_LOOKUP_CORE_DEFINES_SVH
`define TEXT_CACHE_LRU_LOOKUP_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define TCL_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define TCL_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/tcl_pkg.sv
// ----------------------------------------------------------------------------
// Text cache LRU lookup package
// Sizes, codes and the command and status bundles shared by the core.
// ----------------------------------------------------------------------------
package tcl_pkg;

    // Number of cache entries and the derived index widths.
    localparam int ENTRIES   = 128;
    localparam int IDX_W     = $clog2(ENTRIES);
    localparam int CNT_W     = $clog2(ENTRIES + 1);
    localparam int OUT_IDX_W = 7;

    // Field widths of the ports.
    localparam int HASH_W   = 32;
    localparam int FONT_W   = 3;
    localparam int COLOUR_W = 32;
    localparam int LEN_W    = 12;
    localparam int STAMP_W  = 32;
    localparam int STATUS_W = 3;

    // Reset value of the length limit.
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 12'd160;

    typedef enum logic [1:0] {
        OP_LOOKUP = 2'd0,
        OP_TICK   = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_RSVD   = 2'd3
    } tcl_op_t;

    typedef enum logic [STATUS_W-1:0] {
        RES_HIT    = 3'd0,
        RES_MISS   = 3'd1,
        RES_BYPASS = 3'd2,
        RES_FAIL   = 3'd3,
        RES_DONE   = 3'd4
    } tcl_status_t;

    typedef enum logic [1:0] {
        CTL_IDLE,
        CTL_DECODE,
        CTL_SCAN,
        CTL_EMIT
    } tcl_state_t;

    // Tag of one entry.
    typedef struct packed {
        logic [HASH_W-1:0]   hash;
        logic [FONT_W-1:0]   font;
        logic [COLOUR_W-1:0] colour;
    } tcl_tag_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic simple;
        logic scan_start;
        logic scan_step;
        logic commit;
        logic emit;
    } tcl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_scan;
        logic hit;
        logic scan_done;
        logic out_free;
    } tcl_stat_t;

endpackage

>>> rtl/core/tcl_datapath.sv
// ----------------------------------------------------------------------------
// Text cache LRU lookup datapath
// Tag and stamp memories, valid bits, frame clock, scan trackers and the
// output register.
// ----------------------------------------------------------------------------
module tcl_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tcl_pkg::tcl_cmd_t                   cmd,
    output tcl_pkg::tcl_stat_t                  stat,
    input  logic [1:0]                          s_opcode,
    input  logic [tcl_pkg::HASH_W-1:0]          s_key_hash,
    input  logic [tcl_pkg::FONT_W-1:0]          s_font_id,
    input  logic [tcl_pkg::COLOUR_W-1:0]        s_colour,
    input  logic [tcl_pkg::LEN_W-1:0]           s_text_length,
    input  logic                                s_font_present,
    input  logic                                s_render_ok,
    input  logic                                cfg_valid,
    input  logic [tcl_pkg::LEN_W-1:0]           cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tcl_pkg::STATUS_W-1:0]        m_status,
    output logic [tcl_pkg::OUT_IDX_W-1:0]       m_entry_index,
    output logic                                m_evicted
);

    localparam int IDX_W = tcl_pkg::IDX_W;
    localparam int CNT_W = tcl_pkg::CNT_W;

    // Latched input word.
    tcl_pkg::tcl_op_t                 op_reg;
    tcl_pkg::tcl_tag_t                tag_reg;
    logic [tcl_pkg::LEN_W-1:0]        len_reg;
    logic                             present_reg;
    logic                             ok_reg;

    // Configuration and persistent state.
    logic [tcl_pkg::LEN_W-1:0]        max_len_reg;
    logic [tcl_pkg::STAMP_W-1:0]      frame_clk_reg;
    logic [tcl_pkg::ENTRIES-1:0]      valid_reg;

    // Entry memories.
    tcl_pkg::tcl_tag_t                tag_mem   [tcl_pkg::ENTRIES];
    logic [tcl_pkg::STAMP_W-1:0]      stamp_mem [tcl_pkg::ENTRIES];
    tcl_pkg::tcl_tag_t                tag_q_reg;
    logic [tcl_pkg::STAMP_W-1:0]      stamp_q_reg;

    // Scan pointer and compare stage.
    logic [CNT_W-1:0]                 rd_idx_reg;
    logic                             cmp_pend_reg;
    logic [IDX_W-1:0]                 cmp_idx_reg;

    // Victim trackers.
    logic                             have_free_reg;
    logic                             have_free_next;
    logic [IDX_W-1:0]                 free_idx_reg;
    logic [IDX_W-1:0]                 free_idx_next;
    logic                             have_old_reg;
    logic                             have_old_next;
    logic [tcl_pkg::STAMP_W-1:0]      min_stamp_reg;
    logic [tcl_pkg::STAMP_W-1:0]      min_stamp_next;
    logic [IDX_W-1:0]                 min_idx_reg;
    logic [IDX_W-1:0]                 min_idx_next;

    // Pending result and output register.
    tcl_pkg::tcl_status_t             res_status_reg;
    logic [IDX_W-1:0]                 res_idx_reg;
    logic                             res_evict_reg;
    logic                             m_valid_reg;
    tcl_pkg::tcl_status_t             m_status_reg;
    logic [IDX_W-1:0]                 m_idx_reg;
    logic                             m_evicted_reg;

    // Combinational helpers.
    logic                             bypass;
    logic                             cmp_valid;
    logic                             cmp_hit;
    logic                             scan_end;
    logic [IDX_W-1:0]                 victim_idx;
    logic                             victim_was_valid;
    logic [IDX_W-1:0]                 wr_addr;
    logic                             stamp_we;
    logic                             tag_we;
    logic [IDX_W+tcl_pkg::OUT_IDX_W-1:0] idx_ext;

    // Input word capture.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= tcl_pkg::tcl_op_t'(s_opcode);
            tag_reg     <= '{hash: s_key_hash, font: s_font_id, colour: s_colour};
            len_reg     <= s_text_length;
            present_reg <= s_font_present;
            ok_reg      <= s_render_ok;
        end
    end

    // Bypass test and compare stage.
    always_comb begin
        bypass           = !present_reg || (len_reg == '0) || (len_reg >= max_len_reg);
        scan_end         = (rd_idx_reg == CNT_W'(tcl_pkg::ENTRIES));
        cmp_valid        = valid_reg[cmp_idx_reg];
        cmp_hit          = cmp_pend_reg && cmp_valid && (tag_q_reg == tag_reg);
        victim_idx       = have_free_reg ? free_idx_reg : min_idx_reg;
        victim_was_valid = !have_free_reg;
        wr_addr          = cmp_hit ? cmp_idx_reg : victim_idx;
        stamp_we         = cmd.commit && (cmp_hit || ok_reg);
        tag_we           = cmd.commit && !cmp_hit && ok_reg;
    end

    // Status toward the controller.
    always_comb begin
        stat.need_scan = (op_reg == tcl_pkg::OP_LOOKUP) && !bypass;
        stat.hit       = cmp_hit;
        stat.scan_done = scan_end && !cmp_pend_reg;
        stat.out_free  = !m_valid_reg || m_ready;
    end

    // Configuration register and frame clock.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg   <= tcl_pkg::MAX_LEN_RESET;
            frame_clk_reg <= '0;
        end else begin
            if (cfg_valid) begin
                max_len_reg <= cfg_data;
            end
            if (cmd.simple && (op_reg == tcl_pkg::OP_TICK)) begin
                frame_clk_reg <= frame_clk_reg + 1'b1;
            end
        end
    end

    // Valid bits: flush clears all, a miss sets or clears the victim.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.simple && (op_reg == tcl_pkg::OP_FLUSH)) begin
            valid_reg <= '0;
        end else if (cmd.commit && !cmp_hit) begin
            valid_reg[victim_idx] <= ok_reg;
        end
    end

    // Tag memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[wr_addr] <= tag_reg;
        end
        if (cmd.scan_step && !scan_end) begin
            tag_q_reg <= tag_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // Stamp memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (stamp_we) begin
            stamp_mem[wr_addr] <= frame_clk_reg;
        end
        if (cmd.scan_step && !scan_end) begin
            stamp_q_reg <= stamp_mem[rd_idx_reg[IDX_W-1:0]];
        end
    end

    // Scan pointer and compare stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_idx_reg   <= '0;
            cmp_pend_reg <= 1'b0;
            cmp_idx_reg  <= '0;
        end else if (cmd.scan_start || cmd.commit) begin
            rd_idx_reg   <= '0;
            cmp_pend_reg <= 1'b0;
        end else if (cmd.scan_step) begin
            if (scan_end) begin
                cmp_pend_reg <= 1'b0;
            end else begin
                cmp_pend_reg <= 1'b1;
                cmp_idx_reg  <= rd_idx_reg[IDX_W-1:0];
                rd_idx_reg   <= rd_idx_reg + 1'b1;
            end
        end
    end

    // Victim choice: first free entry, else oldest stamp with ties to the lower index.
    always_comb begin
        have_free_next = have_free_reg;
        free_idx_next  = free_idx_reg;
        have_old_next  = have_old_reg;
        min_stamp_next = min_stamp_reg;
        min_idx_next   = min_idx_reg;
        if (cmp_pend_reg && !cmp_hit && !have_free_reg) begin
            if (!cmp_valid) begin
                have_free_next = 1'b1;
                free_idx_next  = cmp_idx_reg;
            end else if (!have_old_reg || (stamp_q_reg < min_stamp_reg)) begin
                have_old_next  = 1'b1;
                min_stamp_next = stamp_q_reg;
                min_idx_next   = cmp_idx_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_free_reg <= 1'b0;
            have_old_reg  <= 1'b0;
        end else if (cmd.scan_start) begin
            have_free_reg <= 1'b0;
            have_old_reg  <= 1'b0;
        end else begin
            have_free_reg <= have_free_next;
            have_old_reg  <= have_old_next;
        end
    end

    always_ff @(posedge aclk) begin
        free_idx_reg  <= free_idx_next;
        min_stamp_reg <= min_stamp_next;
        min_idx_reg   <= min_idx_next;
    end

    // Pending result of the current word.
    always_ff @(posedge aclk) begin
        if (cmd.simple) begin
            res_status_reg <= (op_reg == tcl_pkg::OP_LOOKUP) ? tcl_pkg::RES_BYPASS
                                                             : tcl_pkg::RES_DONE;
            res_idx_reg    <= '0;
            res_evict_reg  <= 1'b0;
        end else if (cmd.commit) begin
            if (cmp_hit) begin
                res_status_reg <= tcl_pkg::RES_HIT;
                res_idx_reg    <= cmp_idx_reg;
                res_evict_reg  <= 1'b0;
            end else if (ok_reg) begin
                res_status_reg <= tcl_pkg::RES_MISS;
                res_idx_reg    <= victim_idx;
                res_evict_reg  <= victim_was_valid;
            end else begin
                res_status_reg <= tcl_pkg::RES_FAIL;
                res_idx_reg    <= '0;
                res_evict_reg  <= victim_was_valid;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_status_reg  <= res_status_reg;
            m_idx_reg     <= res_idx_reg;
            m_evicted_reg <= res_evict_reg;
        end
    end

    // The port carries the low bits of the entry number.
    assign idx_ext       = {{tcl_pkg::OUT_IDX_W{1'b0}}, m_idx_reg};
    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_entry_index = idx_ext[tcl_pkg::OUT_IDX_W-1:0];
    assign m_evicted     = m_evicted_reg;

endmodule

>>> rtl/core/tcl_ctrl.sv
// ----------------------------------------------------------------------------
// Text cache LRU lookup controller
// Sequences decode, the entry scan, the commit and the hand-off of each
// result to the output register.
// ----------------------------------------------------------------------------
module tcl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  tcl_pkg::tcl_stat_t  stat,
    output tcl_pkg::tcl_cmd_t   cmd
);

    tcl_pkg::tcl_state_t state_reg;
    tcl_pkg::tcl_state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tcl_pkg::CTL_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            tcl_pkg::CTL_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = tcl_pkg::CTL_DECODE;
                end
            end
            tcl_pkg::CTL_DECODE: begin
                if (stat.need_scan) begin
                    cmd.scan_start = 1'b1;
                    state_next     = tcl_pkg::CTL_SCAN;
                end else begin
                    cmd.simple = 1'b1;
                    state_next = tcl_pkg::CTL_EMIT;
                end
            end
            tcl_pkg::CTL_SCAN: begin
                if (stat.hit || stat.scan_done) begin
                    cmd.commit = 1'b1;
                    state_next = tcl_pkg::CTL_EMIT;
                end else begin
                    cmd.scan_step = 1'b1;
                end
            end
            tcl_pkg::CTL_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = tcl_pkg::CTL_IDLE;
                end
            end
            default: begin
                state_next = tcl_pkg::CTL_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/text_cache_lru_lookup_core.sv
// ----------------------------------------------------------------------------
// Text cache LRU lookup core
// Fully associative tag store with frame-stamp LRU replacement.
//
//   Channel   Handshake            Moves
//   s_        s_valid / s_ready    one request word (opcode and tag fields)
//   m_        m_valid / m_ready    one result word (status, entry, evicted)
//   cfg_      cfg_valid/cfg_ready  the text length limit
//
// A lookup scans the entries one per cycle through the registered read port
// of the tag and stamp memories; a miss scans every entry, while a hit ends
// the scan at the matching entry. Tick, flush and bypass words skip the scan.
// Reset is synchronous; it clears the valid bits and frame clock and sets the
// length limit back to 160.
// A new word is taken while the previous result still waits on m_ready.
// ----------------------------------------------------------------------------
module text_cache_lru_lookup_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_opcode,
    input  logic [tcl_pkg::HASH_W-1:0]          s_key_hash,
    input  logic [tcl_pkg::FONT_W-1:0]          s_font_id,
    input  logic [tcl_pkg::COLOUR_W-1:0]        s_colour,
    input  logic [tcl_pkg::LEN_W-1:0]           s_text_length,
    input  logic                                s_font_present,
    input  logic                                s_render_ok,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tcl_pkg::STATUS_W-1:0]        m_status,
    output logic [tcl_pkg::OUT_IDX_W-1:0]       m_entry_index,
    output logic                                m_evicted,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tcl_pkg::LEN_W-1:0]           cfg_data
);

    tcl_pkg::tcl_cmd_t  cmd;
    tcl_pkg::tcl_stat_t stat;

    // The limit register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    tcl_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    tcl_datapath u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .stat           (stat),
        .s_opcode       (s_opcode),
        .s_key_hash     (s_key_hash),
        .s_font_id      (s_font_id),
        .s_colour       (s_colour),
        .s_text_length  (s_text_length),
        .s_font_present (s_font_present),
        .s_render_ok    (s_render_ok),
        .cfg_valid      (cfg_valid),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_entry_index  (m_entry_index),
        .m_evicted      (m_evicted)
    );

endmodule

>>> rtl/core/tcl_checker.sv
// ----------------------------------------------------------------------------
// Text cache LRU lookup checker
// Port-level properties of the lookup core, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_cache_lru_lookup_core_defines.svh"

module tcl_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [tcl_pkg::STATUS_W-1:0]        m_status,
    input logic [tcl_pkg::OUT_IDX_W-1:0]       m_entry_index,
    input logic                                m_evicted
);

    // A stalled result word holds its value.
    `TCL_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_entry_index) && $stable(m_evicted), "result word changed while stalled")

    // Only hits and fills name an entry.
    `TCL_ASSERT_IMP(a_idx_zero, aclk, aresetn, m_valid && m_status != tcl_pkg::RES_HIT && m_status != tcl_pkg::RES_MISS, m_entry_index == '0, "entry index set without hit or fill")

    // Hits, bypasses and tick or flush words never evict.
    `TCL_ASSERT_IMP(a_no_evict, aclk, aresetn, m_valid && (m_status == tcl_pkg::RES_HIT || m_status == tcl_pkg::RES_BYPASS || m_status == tcl_pkg::RES_DONE), !m_evicted, "eviction reported for a non-replacing word")

    // One word is in work at a time.
    `TCL_ASSERT_NXT(a_one_word, aclk, aresetn, s_valid && s_ready, !s_ready, "second word accepted while one is in work")

endmodule

bind text_cache_lru_lookup_core tcl_checker u_tcl_checker (.*);
